// ===== rtl/salted_handle_slot_table_macros.svh =====
// Assertion macros for the salted handle slot table.
`ifndef SALTED_HANDLE_SLOT_TABLE_MACROS_SVH
`define SALTED_HANDLE_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sht assertion failed");
`define SHT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sht assertion failed");
`else
`define SHT_ASSERT_IMP(label, ante, cons)
`define SHT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/sht_pkg.sv =====
// Shared types, constants and bit search functions of the slot table.
package sht_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int SALT_BITS_DEF = 16;
  localparam int WORD_BITS     = 32;
  localparam int WORD_SHIFT    = 5;
  localparam logic [15:0] NONE_INDEX = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SCAN   = 2'd2,
    REQ_PLACE  = 2'd3
  } req_t;

  typedef struct packed {
    logic       any;
    logic [4:0] pos;
  } bitpos_t;

  function automatic bitpos_t lowest_set(input logic [WORD_BITS-1:0] w);
    bitpos_t r;
    r.any = 1'b0;
    r.pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.any = 1'b1;
        r.pos = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic bitpos_t highest_set(input logic [WORD_BITS-1:0] w);
    bitpos_t r;
    r.any = 1'b0;
    r.pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        r.any = 1'b1;
        r.pos = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/sht_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
module sht_ram
  import sht_pkg::*;
#(
  parameter int W  = 16,
  parameter int D  = MAX_SLOTS_DEF,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/salted_handle_slot_table.sv =====
// Salted handle slot table: salt RAM, active bitmap RAM and control sequencer.
//
// channel | handshake          | payload
// in      | in_valid/in_ready  | req_type, slot_index, handle_salt
// out     | out_valid/out_ready| found, found_index, found_salt, high_water, live_total
//
// Lookup ends after one read of both RAMs; remove, place and scan may go on to walk the bitmap,
// NW = MAX_SLOTS/32 bitmap words walked one word per cycle from the bitmap RAM; a scan hit
// then reads the found salt. After reset a clearing pass zeroes both RAMs; no request is taken.
// A new request is taken once the previous one is done, even while its result waits.
// A result that cannot leave holds the sequencer until out_ready.
`include "salted_handle_slot_table_macros.svh"
module salted_handle_slot_table
  import sht_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int SALT_BITS = SALT_BITS_DEF,
  parameter int CW = $clog2(MAX_SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    req_type,
  input  logic [15:0]   slot_index,
  input  logic [15:0]   handle_salt,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          found,
  output logic [15:0]   found_index,
  output logic [15:0]   found_salt,
  output logic [CW-1:0] high_water,
  output logic [CW-1:0] live_total
);

  localparam int IW  = $clog2(MAX_SLOTS);
  localparam int NW  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int XW  = WAW + WORD_SHIFT;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(NW - 1);
  localparam logic [CW-1:0]  MAX_CNT   = CW'(MAX_SLOTS);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_RD      = 6'b000100,
    ST_STEP    = 6'b001000,
    ST_SALT_RD = 6'b010000,
    ST_FIN     = 6'b100000
  } state_t;

  state_t state, state_next;
  req_t   req, req_next;
  logic [15:0]          idx, idx_next;
  logic [15:0]          hsalt, hsalt_next;
  logic [WAW-1:0]       wa, wa_next;
  logic [CW-1:0]        hwm, hwm_next;
  logic [CW-1:0]        lf, lf_next;
  logic [CW-1:0]        live, live_next;
  logic                 res_f, res_f_next;
  logic [15:0]          res_fi, res_fi_next;
  logic [SALT_BITS-1:0] res_fs, res_fs_next;
  logic [IW-1:0]        clr, clr_next;

  logic                 salt_we;
  logic [IW-1:0]        salt_waddr, salt_raddr;
  logic [SALT_BITS-1:0] salt_wdata, salt_rdata;
  logic                 bit_we;
  logic [WAW-1:0]       bit_waddr, bit_raddr;
  logic [WORD_BITS-1:0] bit_wdata, bit_rdata;

  logic [WAW-1:0]       idx_w;
  logic [4:0]           idx_b;
  logic [WORD_BITS-1:0] bitv, ge_mask, gt_mask, new_word;
  logic                 in_range;
  logic [SALT_BITS-1:0] place_salt;
  logic [XW-1:0]        pos_full;
  bitpos_t              bp;
  logic                 load_out;

  sht_ram #(.W(SALT_BITS), .D(MAX_SLOTS), .AW(IW)) u_salt_ram (
    .clk   (clk),
    .we    (salt_we),
    .waddr (salt_waddr),
    .wdata (salt_wdata),
    .raddr (salt_raddr),
    .rdata (salt_rdata)
  );

  sht_ram #(.W(WORD_BITS), .D(NW), .AW(WAW)) u_bit_ram (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (bit_wdata),
    .raddr (bit_raddr),
    .rdata (bit_rdata)
  );

  assign in_ready   = (state == ST_IDLE);
  assign idx_w      = WAW'(idx >> WORD_SHIFT);
  assign idx_b      = idx[4:0];
  assign bitv       = WORD_BITS'(1) << idx_b;
  assign ge_mask    = {WORD_BITS{1'b1}} << idx_b;
  assign gt_mask    = ge_mask << 1;
  assign in_range   = ({1'b0, idx} < 17'(MAX_SLOTS));
  assign place_salt = hsalt[SALT_BITS-1:0];
  assign load_out   = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next  = state;
    req_next    = req;
    idx_next    = idx;
    hsalt_next  = hsalt;
    wa_next     = wa;
    hwm_next    = hwm;
    lf_next     = lf;
    live_next   = live;
    res_f_next  = res_f;
    res_fi_next = res_fi;
    res_fs_next = res_fs;
    clr_next    = clr;
    salt_we     = 1'b0;
    salt_waddr  = IW'(idx);
    salt_wdata  = '0;
    salt_raddr  = IW'(idx);
    bit_we      = 1'b0;
    bit_waddr   = idx_w;
    bit_wdata   = '0;
    bit_raddr   = wa;
    new_word    = '0;
    pos_full    = '0;
    bp          = '0;

    unique case (state)
      ST_CLEAR: begin
        salt_we    = 1'b1;
        salt_waddr = clr;
        bit_we     = ({1'b0, clr} < (IW + 1)'(NW));
        bit_waddr  = WAW'(clr);
        clr_next   = clr + IW'(1);
        if (clr == IW'(MAX_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        salt_raddr = IW'(slot_index);
        bit_raddr  = WAW'(slot_index >> WORD_SHIFT);
        if (in_valid) begin
          req_next    = req_t'(req_type);
          idx_next    = slot_index;
          hsalt_next  = handle_salt;
          wa_next     = WAW'(slot_index >> WORD_SHIFT);
          res_f_next  = 1'b0;
          res_fi_next = NONE_INDEX;
          res_fs_next = '0;
          state_next  = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_FIN;
        unique case (req)
          REQ_LOOKUP: begin
            if (idx != NONE_INDEX && {1'b0, idx} < 17'(hwm) && salt_rdata != '0 &&
                16'(salt_rdata) == hsalt) begin
              res_f_next  = 1'b1;
              res_fi_next = idx;
              res_fs_next = salt_rdata;
            end
          end
          REQ_REMOVE: begin
            if (in_range) begin
              if ((bit_rdata & bitv) != '0) begin
                res_f_next  = 1'b1;
                res_fi_next = idx;
                res_fs_next = salt_rdata;
              end
              new_word  = bit_rdata & ~bitv;
              salt_we   = 1'b1;
              bit_we    = 1'b1;
              bit_wdata = new_word;
              if ({1'b0, idx} < 17'(lf)) begin
                lf_next = CW'(idx);
              end
              if (live != '0) begin
                live_next = live - CW'(1);
              end
              if ({1'b0, idx} + 17'd1 == 17'(hwm)) begin
                bp = highest_set(new_word);
                if (bp.any) begin
                  pos_full = {idx_w, bp.pos};
                  hwm_next = CW'(pos_full) + CW'(1);
                end else if (idx_w == '0) begin
                  hwm_next = '0;
                end else begin
                  wa_next    = idx_w - WAW'(1);
                  bit_raddr  = idx_w - WAW'(1);
                  state_next = ST_STEP;
                end
              end
            end
          end
          REQ_SCAN: begin
            if (idx != NONE_INDEX && in_range) begin
              bp = lowest_set(bit_rdata & ge_mask);
              if (bp.any) begin
                pos_full    = {idx_w, bp.pos};
                res_fi_next = 16'(pos_full);
                salt_raddr  = IW'(pos_full);
                state_next  = ST_SALT_RD;
              end else if (idx_w != LAST_WORD) begin
                wa_next    = idx_w + WAW'(1);
                bit_raddr  = idx_w + WAW'(1);
                state_next = ST_STEP;
              end
            end
          end
          REQ_PLACE: begin
            if (in_range && place_salt != '0) begin
              if ((bit_rdata & bitv) == '0 && live < MAX_CNT) begin
                live_next = live + CW'(1);
              end
              new_word    = bit_rdata | bitv;
              salt_we     = 1'b1;
              salt_wdata  = place_salt;
              bit_we      = 1'b1;
              bit_wdata   = new_word;
              res_f_next  = 1'b1;
              res_fi_next = idx;
              res_fs_next = place_salt;
              if (17'(hwm) < {1'b0, idx} + 17'd1) begin
                hwm_next = CW'(idx) + CW'(1);
              end
              if ({1'b0, idx} == 17'(lf)) begin
                bp = lowest_set(~new_word & gt_mask);
                if (bp.any) begin
                  pos_full = {idx_w, bp.pos};
                  lf_next  = (17'(pos_full) < 17'(MAX_SLOTS)) ? CW'(pos_full) : MAX_CNT;
                end else if (idx_w == LAST_WORD) begin
                  lf_next = MAX_CNT;
                end else begin
                  wa_next    = idx_w + WAW'(1);
                  bit_raddr  = idx_w + WAW'(1);
                  state_next = ST_STEP;
                end
              end
            end
          end
          default: ;
        endcase
      end
      ST_STEP: begin
        state_next = ST_FIN;
        unique case (req)
          REQ_REMOVE: begin
            bp = highest_set(bit_rdata);
            if (bp.any) begin
              pos_full = {wa, bp.pos};
              hwm_next = CW'(pos_full) + CW'(1);
            end else if (wa == '0) begin
              hwm_next = '0;
            end else begin
              wa_next    = wa - WAW'(1);
              bit_raddr  = wa - WAW'(1);
              state_next = ST_STEP;
            end
          end
          REQ_SCAN: begin
            bp = lowest_set(bit_rdata);
            if (bp.any) begin
              pos_full    = {wa, bp.pos};
              res_fi_next = 16'(pos_full);
              salt_raddr  = IW'(pos_full);
              state_next  = ST_SALT_RD;
            end else if (wa != LAST_WORD) begin
              wa_next    = wa + WAW'(1);
              bit_raddr  = wa + WAW'(1);
              state_next = ST_STEP;
            end
          end
          REQ_PLACE: begin
            bp = lowest_set(~bit_rdata);
            if (bp.any) begin
              pos_full = {wa, bp.pos};
              lf_next  = (17'(pos_full) < 17'(MAX_SLOTS)) ? CW'(pos_full) : MAX_CNT;
            end else if (wa == LAST_WORD) begin
              lf_next = MAX_CNT;
            end else begin
              wa_next    = wa + WAW'(1);
              bit_raddr  = wa + WAW'(1);
              state_next = ST_STEP;
            end
          end
          default: ;
        endcase
      end
      ST_SALT_RD: begin
        res_f_next  = 1'b1;
        res_fs_next = salt_rdata;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      hwm       <= '0;
      lf        <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      hwm   <= hwm_next;
      lf    <= lf_next;
      live  <= live_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req    <= req_next;
    idx    <= idx_next;
    hsalt  <= hsalt_next;
    wa     <= wa_next;
    res_f  <= res_f_next;
    res_fi <= res_fi_next;
    res_fs <= res_fs_next;
    if (load_out) begin
      found       <= res_f;
      found_index <= res_fi;
      found_salt  <= 16'(res_fs);
      high_water  <= hwm;
      live_total  <= live;
    end
  end

  `SHT_ASSERT_NXT(a_accept_reads, in_valid && in_ready, state == ST_RD)
  `SHT_ASSERT_NXT(a_fin_loads, load_out, out_valid && state == ST_IDLE)
  `SHT_ASSERT_IMP(a_counts_bounded, state != ST_CLEAR, (hwm <= MAX_CNT) && (lf <= MAX_CNT) && (live <= MAX_CNT))

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the salted handle slot table: directed and random requests.
module tb_top;
  import sht_pkg::*;

  localparam int SLOTS = 1024;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic        found;
    logic [15:0] index;
    logic [15:0] salt;
    logic [10:0] mark;
    logic [10:0] live;
  } slot_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [15:0] slot_index = '0;
  logic [15:0] handle_salt = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [15:0] found_index;
  logic [15:0] found_salt;
  logic [10:0] high_water;
  logic [10:0] live_total;

  salted_handle_slot_table i_dut (.*);

  always #4 clk = ~clk;

  // shadow table
  logic [15:0] shadow_salt [SLOTS];
  logic        shadow_active [SLOTS];
  int          shadow_mark, shadow_lowest, shadow_live;

  slot_result_t pending_results[$];
  int send_idle, recv_idle;
  int mismatches, checked, cycles;
  int requests_sent;

  task automatic table_apply(input req_t t, input logic [15:0] idx, input logic [15:0] salt);
    slot_result_t r;
    int i;
    r.found = 1'b0;
    r.index = NONE_INDEX;
    r.salt = '0;
    case (t)
      REQ_LOOKUP: begin
        if (idx != NONE_INDEX && idx < shadow_mark && idx < SLOTS) begin
          if (shadow_salt[idx] != 0 && shadow_salt[idx] == salt) begin
            r.found = 1'b1; r.index = idx; r.salt = salt;
          end
        end
      end
      REQ_REMOVE: begin
        if (idx < SLOTS) begin
          if (shadow_active[idx]) begin
            r.found = 1'b1; r.index = idx; r.salt = shadow_salt[idx];
          end
          shadow_active[idx] = 1'b0;
          shadow_salt[idx] = '0;
          if (idx < shadow_lowest) shadow_lowest = idx;
          if (idx + 1 == shadow_mark) begin
            do shadow_mark--; while (shadow_mark > 0 && shadow_salt[shadow_mark-1] == 0);
          end
          if (shadow_live > 0) shadow_live--;
        end
      end
      REQ_SCAN: begin
        if (idx != NONE_INDEX) begin
          for (i = idx; i < shadow_mark && i < SLOTS; i++) begin
            if (shadow_active[i]) begin
              r.found = 1'b1; r.index = 16'(i); r.salt = shadow_salt[i];
              break;
            end
          end
        end
      end
      default: begin
        if (idx < SLOTS && salt != 0) begin
          if (!shadow_active[idx] && shadow_live < SLOTS) shadow_live++;
          shadow_active[idx] = 1'b1;
          shadow_salt[idx] = salt;
          if (shadow_mark < idx + 1) shadow_mark = idx + 1;
          if (idx == shadow_lowest) begin
            i = idx + 1;
            while (i < SLOTS && shadow_active[i]) i++;
            shadow_lowest = i;
          end
          r.found = 1'b1; r.index = idx; r.salt = salt;
        end
      end
    endcase
    r.mark = 11'(shadow_mark);
    r.live = 11'(shadow_live);
    pending_results.push_back(r);
  endtask

  task automatic send_request(input req_t t, input logic [15:0] idx, input logic [15:0] salt);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= t;
    slot_index <= idx;
    handle_salt <= salt;
    do @(posedge clk); while (!in_ready);
    table_apply(t, idx, salt);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    slot_result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result idx=%0d", found_index);
        end else begin
          e = pending_results.pop_front();
          if (found !== e.found || found_index !== e.index || found_salt !== e.salt ||
              high_water !== e.mark || live_total !== e.live) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0b/%0d/%h/%0d/%0d got %0b/%0d/%h/%0d/%0d",
                       e.found, e.index, e.salt, e.mark, e.live,
                       found, found_index, found_salt, high_water, live_total);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(REQ_LOOKUP, 16'd0, 16'd0);
    send_request(REQ_SCAN, 16'd0, 16'd0);
    send_request(REQ_REMOVE, 16'd5, 16'd0);
    send_request(REQ_PLACE, 16'd0, 16'd1);
    send_request(REQ_PLACE, 16'd1023, 16'hFFFF);
    send_request(REQ_PLACE, 16'd1024, 16'h1234);
    send_request(REQ_PLACE, 16'hFFFF, 16'h5555);
    send_request(REQ_PLACE, 16'd7, 16'd0);
    send_request(REQ_PLACE, 16'd1, 16'hAAAA);
    send_request(REQ_PLACE, 16'd1, 16'h5555);
    send_request(REQ_LOOKUP, 16'd1023, 16'hFFFF);
    send_request(REQ_LOOKUP, 16'd1, 16'hAAAA);
    send_request(REQ_LOOKUP, 16'd0, 16'd2);
    send_request(REQ_LOOKUP, 16'hFFFF, 16'hFFFF);
    send_request(REQ_LOOKUP, 16'd2000, 16'd1);
    send_request(REQ_SCAN, 16'd2, 16'd0);
    send_request(REQ_SCAN, 16'hFFFF, 16'd0);
    send_request(REQ_SCAN, 16'd1023, 16'd0);
    send_request(REQ_REMOVE, 16'd1023, 16'd0);
    send_request(REQ_SCAN, 16'd1023, 16'd0);
    send_request(REQ_REMOVE, 16'hFFFF, 16'd0);
    send_request(REQ_REMOVE, 16'd1, 16'd0);
    send_request(REQ_REMOVE, 16'd0, 16'd0);
    send_request(REQ_REMOVE, 16'd0, 16'd0);
    send_request(REQ_LOOKUP, 16'd0, 16'd1);
  endtask

  task automatic test_random(input int count);
    int n, sel;
    req_t t;
    logic [15:0] idx, salt;
    for (n = 0; n < count; n++) begin
      t = req_t'($urandom_range(3));
      sel = $urandom_range(99);
      if (sel < 15 && shadow_mark > 0) idx = 16'(shadow_mark - 1);
      else if (sel < 75) idx = 16'($urandom_range(63));
      else if (sel < 90) idx = 16'($urandom_range(SLOTS - 1));
      else idx = 16'($urandom);
      salt = 16'($urandom);
      if (sel % 4 == 0) salt = 16'($urandom_range(3));
      if (t == REQ_LOOKUP && idx < SLOTS && $urandom_range(9) < 7) salt = shadow_salt[idx];
      send_request(t, idx, salt);
    end
  endtask

  initial begin
    foreach (shadow_salt[k]) begin
      shadow_salt[k] = '0;
      shadow_active[k] = 1'b0;
    end
    shadow_mark = 0; shadow_lowest = 0; shadow_live = 0;
    mismatches = 0; checked = 0; cycles = 0; requests_sent = 0;
    send_idle = 0; recv_idle = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle = 27; recv_idle = 60;
    test_directed();
    test_random(250);
    send_idle = 60; recv_idle = 27;
    test_random(250);
    send_idle = 0; recv_idle = 0;
    test_random(250);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d requests, %0d results checked", requests_sent, checked);
    $display("lookups, removes, scans and places under sender and receiver stalls");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/sht_pkg.sv
rtl/sht_ram.sv
rtl/salted_handle_slot_table.sv
test/tb_top.sv
